// ----- hdl/sic_pkg.sv -----
// ----------------------------------------------------------------------------
// sic_pkg: shared types and codes for the interning cache
// Result codes, command values, reset and saturation constants, the control
// word sent down the row of slot cells, and the controller state type.
// ----------------------------------------------------------------------------
package sic_pkg;

    // result codes carried in m_tuser
    typedef enum logic [2:0] {
        OUT_EMPTY    = 3'd0,
        OUT_TOO_LONG = 3'd1,
        OUT_HIT      = 3'd2,
        OUT_INSERTED = 3'd3,
        OUT_FULL     = 3'd4,
        OUT_FLUSHED  = 3'd5
    } outcome_t;

    // command field values
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // reset value of the aging threshold register
    localparam logic [6:0] AGE_THRESHOLD_RESET = 7'd25;

    // saturation limit of a slot's hit counter
    localparam logic [7:0] HITS_MAX = 8'hFF;

    // control word broadcast to every slot cell
    typedef struct packed {
        logic compare;  // latch match and lowest-free flags
        logic hit;      // bump the counter of the matching cell
        logic insert;   // write the key into the first free cell
        logic age;      // free zero-hit cells, halve the rest
        logic flush;    // free every cell
    } sic_ctl_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DEC,
        ST_APPLY
    } state_t;

endpackage

// ----- hdl/sic_cell.sv -----
// ----------------------------------------------------------------------------
// sic_cell: one slot of the interning cache
// Holds used bit, key, length and hit counter. Compares against the broadcast
// key, passes the "free slot seen" flag to its right neighbor, and applies
// hit, insert, aging and flush updates.
// ----------------------------------------------------------------------------
module sic_cell #(
    parameter int KEY_W = 64,
    parameter int LEN_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sic_pkg::sic_ctl_t ctl,
    input  logic [KEY_W-1:0]  key,
    input  logic [LEN_W-1:0]  len,
    input  logic              free_in,
    output logic              free_out,
    output logic              match,
    output logic              lowest_free,
    output logic [7:0]        hits
);
    import sic_pkg::*;

    logic             used_reg;
    logic [KEY_W-1:0] key_reg;
    logic [LEN_W-1:0] len_reg;
    logic [7:0]       hits_reg;
    logic             match_reg;
    logic             first_reg;

    // free-slot flag ripples toward higher slots
    assign free_out    = free_in | ~used_reg;
    assign match       = match_reg;
    assign lowest_free = first_reg;
    assign hits        = hits_reg;

    // compare phase flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else if (ctl.compare)
        begin
            match_reg <= used_reg && (len_reg == len) && (key_reg == key);
            first_reg <= ~used_reg & ~free_in;
        end
    end

    // used bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else if (ctl.flush)
            used_reg <= 1'b0;
        else if (ctl.insert && first_reg)
            used_reg <= 1'b1;
        else if (ctl.age && used_reg && (hits_reg == 8'd0))
            used_reg <= 1'b0;
    end

    // payload: key, length, counter
    always_ff @(posedge clk)
    begin
        if (ctl.insert && first_reg)
        begin
            key_reg  <= key;
            len_reg  <= len;
            // a fresh entry ends at zero hits with or without aging
            hits_reg <= 8'd0;
        end
        else if (ctl.hit && match_reg)
        begin
            if (hits_reg != HITS_MAX)
                hits_reg <= hits_reg + 8'd1;
        end
        else if (ctl.age && used_reg)
        begin
            hits_reg <= hits_reg >> 1;
        end
    end

endmodule

// ----- hdl/string_intern_cache_with_aging.sv -----
// ----------------------------------------------------------------------------
// string_intern_cache_with_aging: short-key interning cache with hit aging
// Row of slot cells driven by a small controller.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one beat per command: s_tuser is the command (lookup or
//   flush), s_tdata carries the key bytes and key length. m_* channel returns
//   one beat per command: m_tuser is the outcome, m_tdata slot and hit count.
//   cfg_* channel writes the aging threshold; write it only while idle.
// Timing:
//   The result beat is offered once the input beat has passed through
//   parallel compare in every cell (also locating the lowest free slot),
//   decision (one-hot encode and counter readout across the row), then the
//   update of all cells as the result is registered. The next beat is taken
//   once the update is done, so beats do not overlap.
// Reset: every slot is free, the insert count is zero, threshold is 25.
// Stall: a result waiting on m_tready holds the controller in its update
//   phase; the cells only update once the result register can take the beat.
// ----------------------------------------------------------------------------
module string_intern_cache_with_aging #(
    parameter int CAPACITY      = 64,
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] key, [71:64] key_length
    input  logic [0:0]  s_tuser,   // [0] command
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] slot, [13:6] hit_count, [15:14] zero
    output logic [2:0]  m_tuser,   // [2:0] outcome
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // age_threshold
);
    import sic_pkg::*;

    localparam int KEY_W = MAX_KEY_BYTES * 8;
    localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    state_t state_reg, state_next;

    logic [6:0]  thr_reg;
    logic [6:0]  icount_reg;
    logic        cmd_reg;
    logic [63:0] key_reg;
    logic [7:0]  len_reg;
    logic [63:0] key_masked;

    // decision results
    sic_ctl_t    plan_reg;
    outcome_t    res_outcome_reg;
    logic [5:0]  res_slot_reg;
    logic [7:0]  res_hits_reg;
    sic_ctl_t    plan_next;
    outcome_t    res_outcome_next;
    logic [5:0]  res_slot_next;
    logic [7:0]  res_hits_next;

    // output register
    logic        m_valid_reg;
    outcome_t    m_outcome_reg;
    logic [5:0]  m_slot_reg;
    logic [7:0]  m_hits_reg;

    sic_ctl_t    ctl;
    logic        apply_go;

    // row signals
    logic [CAPACITY:0]  free_chain;
    logic [CAPACITY-1:0] match_v;
    logic [CAPACITY-1:0] first_v;
    logic [7:0]          hits_v [CAPACITY];

    // decision logic
    logic [CAPACITY-1:0] sel_v;
    logic [IDX_W-1:0]    sel_idx;
    logic [7:0]          sel_hits;
    logic                any_hit;
    logic                any_free;
    logic [7:0]          count_inc;

    // ------------------------------------------------------------------
    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_outcome_reg;
    assign m_tdata   = {2'b00, m_hits_reg, m_slot_reg};

    assign apply_go = (state_reg == ST_APPLY) && (!m_valid_reg || m_tready);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= AGE_THRESHOLD_RESET;
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    // key bytes beyond the length are cleared
    always_comb
    begin
        for (int b = 0; b < 8; b++)
            key_masked[b*8 +: 8] = (8'(b) < s_tdata[71:64]) ? s_tdata[b*8 +: 8] : 8'h00;
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser[0];
            key_reg <= key_masked;
            len_reg <= s_tdata[71:64];
        end
    end

    // ------------------------------------------------------------------
    // controller: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_CMP;
            ST_CMP:   state_next = ST_DEC;
            ST_DEC:   state_next = ST_APPLY;
            ST_APPLY: if (apply_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // controller: cell control word
    always_comb
    begin
        ctl         = '0;
        ctl.compare = (state_reg == ST_CMP);
        if (apply_go)
        begin
            ctl.hit    = plan_reg.hit;
            ctl.insert = plan_reg.insert;
            ctl.age    = plan_reg.age;
            ctl.flush  = plan_reg.flush;
        end
    end

    // ------------------------------------------------------------------
    // row of slot cells
    assign free_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sic_cell #(
            .KEY_W (KEY_W),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .key         (key_reg[KEY_W-1:0]),
            .len         (len_reg[LEN_W-1:0]),
            .free_in     (free_chain[i]),
            .free_out    (free_chain[i+1]),
            .match       (match_v[i]),
            .lowest_free (first_v[i]),
            .hits        (hits_v[i])
        );
    end

    // ------------------------------------------------------------------
    // decision: encode the selected cell and read its counter
    assign any_hit  = |match_v;
    // end of the free chain: some slot is free (cells are unchanged since compare)
    assign any_free = free_chain[CAPACITY];
    assign sel_v    = any_hit ? match_v : first_v;

    always_comb
    begin
        sel_idx  = '0;
        sel_hits = 8'd0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (sel_v[i])
            begin
                sel_idx  = sel_idx | IDX_W'(i);
                sel_hits = sel_hits | hits_v[i];
            end
        end
    end

    assign count_inc = {1'b0, icount_reg} + 8'd1;

    // plan and result for the current beat
    always_comb
    begin
        plan_next        = '0;
        res_outcome_next = OUT_FULL;
        res_slot_next    = 6'd0;
        res_hits_next    = 8'd0;
        if (cmd_reg == CMD_FLUSH)
        begin
            plan_next.flush  = 1'b1;
            res_outcome_next = OUT_FLUSHED;
        end
        else if (len_reg == 8'd0)
            res_outcome_next = OUT_EMPTY;
        else if (len_reg > 8'(MAX_KEY_BYTES))
            res_outcome_next = OUT_TOO_LONG;
        else if (any_hit)
        begin
            plan_next.hit    = 1'b1;
            res_outcome_next = OUT_HIT;
            res_slot_next    = 6'(sel_idx);
            res_hits_next    = (sel_hits == HITS_MAX) ? HITS_MAX : sel_hits + 8'd1;
        end
        else if (any_free)
        begin
            plan_next.insert = 1'b1;
            plan_next.age    = (count_inc > {1'b0, thr_reg});
            res_outcome_next = OUT_INSERTED;
            res_slot_next    = 6'(sel_idx);
        end
        else
        begin
            plan_next.age    = 1'b1;
            res_outcome_next = OUT_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plan_reg <= '0;
        else if (state_reg == ST_DEC)
            plan_reg <= plan_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DEC)
        begin
            res_outcome_reg <= res_outcome_next;
            res_slot_reg    <= res_slot_next;
            res_hits_reg    <= res_hits_next;
        end
    end

    // insert count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            icount_reg <= 7'd0;
        else if (apply_go)
        begin
            if (plan_reg.flush || plan_reg.age)
                icount_reg <= 7'd0;
            else if (plan_reg.insert)
                icount_reg <= count_inc[6:0];
        end
    end

    // ------------------------------------------------------------------
    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (apply_go)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (apply_go)
        begin
            m_outcome_reg <= res_outcome_reg;
            m_slot_reg    <= res_slot_reg;
            m_hits_reg    <= res_hits_reg;
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for string_intern_cache_with_aging
// Drives lookup and flush beats with random gaps and stalls, and keeps its
// own copy of the slot table to predict each outcome. It writes the aging
// threshold between phases and checks each result beat in order.
// ----------------------------------------------------------------------------
import sic_pkg::*;

localparam int NUM_SLOTS     = 64;
localparam int KEY_BYTES_MAX = 8;

// one predicted result beat
typedef struct packed {
    outcome_t    outcome;
    logic [5:0]  slot;
    logic [7:0]  hits;
} lookup_result_t;

// bytes of a key that take part in the compare
function automatic logic [63:0] key_mask(input logic [7:0] key_len);
    if (key_len >= KEY_BYTES_MAX)
        return '1;
    return (64'd1 << (8 * key_len)) - 64'd1;
endfunction

// ----------------------------------------------------------------------------
// Slot table copy, expected result queue and the checker
// ----------------------------------------------------------------------------
class intern_scoreboard;
    bit              entry_live [NUM_SLOTS];
    logic [63:0]     entry_key  [NUM_SLOTS];
    logic [3:0]      entry_len  [NUM_SLOTS];
    logic [7:0]      entry_hits [NUM_SLOTS];
    logic [6:0]      inserts_since_age;
    logic [6:0]      age_limit;
    lookup_result_t  expected_outcomes [$];
    int              failures;

    function new();
        foreach (entry_live[i])
            entry_live[i] = 1'b0;
        inserts_since_age = '0;
        age_limit         = AGE_THRESHOLD_RESET;
        failures          = 0;
    endfunction

    // free cold entries, halve the rest
    function void age_entries();
        foreach (entry_live[i])
        begin
            if (entry_live[i])
            begin
                if (entry_hits[i] == 8'd0)
                    entry_live[i] = 1'b0;
                else
                    entry_hits[i] = entry_hits[i] >> 1;
            end
        end
        inserts_since_age = '0;
    endfunction

    function void flag(string what);
        failures++;
        if (failures <= 10)
            $display("[%0t] ERROR: %s", $time, what);
    endfunction

    // accepted input beat: update the table and queue the expected result
    function void note_lookup(logic command, logic [63:0] key, logic [7:0] key_len);
        lookup_result_t  res;
        logic [63:0]     masked;
        logic [7:0]      bumped;
        int              found;
        int              free_slot;
        res.outcome = OUT_EMPTY;
        res.slot    = '0;
        res.hits    = '0;
        if (command == CMD_FLUSH)
        begin
            foreach (entry_live[i])
                entry_live[i] = 1'b0;
            inserts_since_age = '0;
            res.outcome = OUT_FLUSHED;
        end
        else if (key_len == 8'd0)
            res.outcome = OUT_EMPTY;
        else if (key_len > KEY_BYTES_MAX)
            res.outcome = OUT_TOO_LONG;
        else
        begin
            masked = key & key_mask(key_len);
            found  = -1;
            for (int i = 0; i < NUM_SLOTS && found < 0; i++)
                if (entry_live[i] && entry_len[i] == key_len[3:0] && entry_key[i] == masked)
                    found = i;
            if (found >= 0)
            begin
                // hit: counter saturates
                if (entry_hits[found] != HITS_MAX)
                    entry_hits[found] = entry_hits[found] + 8'd1;
                res.outcome = OUT_HIT;
                res.slot    = 6'(found);
                res.hits    = entry_hits[found];
            end
            else
            begin
                free_slot = -1;
                for (int i = 0; i < NUM_SLOTS && free_slot < 0; i++)
                    if (!entry_live[i])
                        free_slot = i;
                if (free_slot < 0)
                begin
                    // table full: age and bypass
                    age_entries();
                    res.outcome = OUT_FULL;
                end
                else
                begin
                    entry_live[free_slot] = 1'b1;
                    entry_key[free_slot]  = masked;
                    entry_len[free_slot]  = key_len[3:0];
                    entry_hits[free_slot] = 8'd0;
                    bumped = {1'b0, inserts_since_age} + 8'd1;
                    // past the threshold the new entry gets one hit, then all age
                    if (bumped > {1'b0, age_limit})
                    begin
                        entry_hits[free_slot] = 8'd1;
                        age_entries();
                    end
                    else
                        inserts_since_age = bumped[6:0];
                    res.outcome = OUT_INSERTED;
                    res.slot    = 6'(free_slot);
                    res.hits    = entry_hits[free_slot];
                end
            end
        end
        expected_outcomes.push_back(res);
    endfunction

    // accepted result beat against the oldest expectation
    function void check_result(logic [2:0] outcome, logic [5:0] slot, logic [7:0] hits);
        lookup_result_t want;
        if (expected_outcomes.size() == 0)
            flag($sformatf("outcome %0d slot %0d hits %0d arrived with nothing pending",
                           outcome, slot, hits));
        else
        begin
            want = expected_outcomes.pop_front();
            if (outcome !== want.outcome || slot !== want.slot || hits !== want.hits)
                flag($sformatf("expected %s slot %0d hits %0d, got outcome %0d slot %0d hits %0d",
                               want.outcome.name(), want.slot, want.hits,
                               outcome, slot, hits));
        end
    endfunction
endclass

module testbench;

    localparam int STALL_MAX  = 12;
    localparam int IDLE_LIMIT = 1000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;    // [63:0] key, [71:64] key_length
    logic [0:0]   s_tuser;    // [0] command
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;    // [5:0] slot, [13:6] hit_count, [15:14] zero
    logic [2:0]   m_tuser;    // [2:0] outcome
    logic         cfg_valid;
    logic         cfg_ready;
    logic [6:0]   cfg_data;   // age_threshold

    intern_scoreboard  cache_check;
    bit                send_burst;
    bit                recv_burst;
    int                idle_cycles = 0;

    string_intern_cache_with_aging #(
        .CAPACITY      (NUM_SLOTS),
        .MAX_KEY_BYTES (KEY_BYTES_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one input beat; handshake sampled at the falling edge
    task automatic send_command(input logic command, input logic [63:0] key,
                                input logic [7:0] key_len);
        int  gap;
        bit  taken;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key_len, key};
        s_tuser  <= command;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        cache_check.note_lookup(command, key, key_len);
    endtask

    // wait until idle, then load a new aging threshold
    task automatic set_threshold(input logic [6:0] value);
        bit taken;
        s_tvalid <= 1'b0;
        while (cache_check.expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        cache_check.age_limit = value;
    endtask

    // lookups from a pool of keys, with flushes and malformed lengths mixed in
    task automatic run_traffic(input int count, input int pool_size,
                               input int flush_pct, input int noise_pct);
        logic [63:0]  keys [];
        logic [7:0]   lens [];
        logic [63:0]  mask;
        logic [63:0]  key;
        int           pick;
        int           roll;
        keys = new[pool_size];
        lens = new[pool_size];
        foreach (keys[i])
        begin
            keys[i] = {$urandom, $urandom};
            lens[i] = ($urandom_range(0, 3) == 0) ? 8'(KEY_BYTES_MAX)
                                                  : 8'($urandom_range(1, KEY_BYTES_MAX));
        end
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < flush_pct)
                send_command(CMD_FLUSH, {$urandom, $urandom}, 8'($urandom));
            else if (roll < flush_pct + noise_pct)
                send_command(CMD_LOOKUP, {$urandom, $urandom},
                             $urandom_range(0, 1) ? 8'd0
                                                  : 8'($urandom_range(KEY_BYTES_MAX + 1, 255)));
            else
            begin
                // same key, sometimes with junk above its length
                pick = $urandom_range(0, pool_size - 1);
                mask = key_mask(lens[pick]);
                key  = keys[pick] & mask;
                if ($urandom_range(0, 1))
                    key = key | ({$urandom, $urandom} & ~mask);
                send_command(CMD_LOOKUP, key, lens[pick]);
            end
        end
    endtask

    // result side: random stalls, checks every accepted beat
    initial
    begin : result_sink
        int          gap;
        bit          taken;
        logic [2:0]  outcome_seen;
        logic [5:0]  slot_seen;
        logic [7:0]  hits_seen;
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                taken        = m_tvalid;
                outcome_seen = m_tuser;
                slot_seen    = m_tdata[5:0];
                hits_seen    = m_tdata[13:6];
                @(posedge clk);
            end
            while (!taken);
            cache_check.check_result(outcome_seen, slot_seen, hits_seen);
        end
    end

    // watchdog: too long without any beat on any channel
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        cache_check = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats at the reset threshold
        send_command(CMD_LOOKUP, '1, 8'd0);                          // empty key
        send_command(CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, 8'd9);     // one byte too long
        send_command(CMD_LOOKUP, '0, 8'd255);                        // longest length
        send_command(CMD_LOOKUP, '1, 8'd8);                          // insert, all ones
        send_command(CMD_LOOKUP, '1, 8'd8);                          // hit
        send_command(CMD_LOOKUP, 64'hDEAD_BEEF_CAFE_0041, 8'd1);     // junk above length
        send_command(CMD_LOOKUP, 64'h1234_5678_9ABC_DE41, 8'd1);     // hit, other junk
        send_command(CMD_LOOKUP, 64'h0000_0000_0000_0041, 8'd2);     // same bytes, longer
        send_command(CMD_LOOKUP, '0, 8'd8);                          // all-zero key
        send_command(CMD_LOOKUP, 64'h0000_0000_8000_0000, 8'd4);
        send_command(CMD_LOOKUP, 64'h8000_0000_0000_0000, 8'd8);
        send_command(CMD_FLUSH, 64'hA5A5_A5A5_A5A5_A5A5, 8'd200);    // flush with junk fields
        send_command(CMD_LOOKUP, '1, 8'd8);                          // back into the first slot
        send_command(CMD_FLUSH, '0, 8'd0);
        run_traffic(150, 48, 2, 8);

        // highest threshold: fill every slot, then overflow
        set_threshold(7'd127);
        send_command(CMD_FLUSH, '0, 8'd0);
        repeat (NUM_SLOTS + 2)
            send_command(CMD_LOOKUP, {$urandom, $urandom}, 8'($urandom_range(4, KEY_BYTES_MAX)));
        run_traffic(200, 96, 0, 5);

        // every insert ages
        set_threshold(7'd0);
        run_traffic(150, 16, 2, 5);

        set_threshold(7'd1);
        run_traffic(150, 24, 2, 5);

        set_threshold(7'd64);
        run_traffic(100, 80, 1, 5);

        // one hot key until its counter saturates
        set_threshold(AGE_THRESHOLD_RESET);
        send_command(CMD_FLUSH, '0, 8'd0);
        run_traffic(300, 1, 0, 5);

        set_threshold(7'($urandom_range(1, 64)));
        run_traffic(100, 40, 2, 8);

        // drain, then a few quiet cycles for stray beats
        s_tvalid <= 1'b0;
        while (cache_check.expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (cache_check.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
